@@ rtl/mdpad_pkg.sv @@
// Shared types, constants and helper functions of the MD5 / SHA-1 message padder.
// No dependencies; used by the controller, datapath and top level of the padder.
package mdpad_pkg;

    localparam int unsigned COUNT_W   = 61;
    localparam int unsigned PARTIAL_W = 24;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WIDX_W    = 4;

    localparam logic [BYTE_W-1:0] PAD_BYTE       = 8'h80;
    localparam logic [5:0]        LEN_START_BYTE = 6'd56;
    localparam logic [WIDX_W-1:0] LEN_HI_WIDX    = 4'd14;
    localparam logic [WIDX_W-1:0] LAST_WIDX      = 4'd15;

    // Values of the command flag on the input channel.
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // Values of the algorithm register.
    localparam logic ALG_SHA1 = 1'b0;
    localparam logic ALG_MD5  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_byte;
        logic start_pad;
        logic emit_pad;
    } mdpad_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;
        logic pad_last;
    } mdpad_stat_t;

    function automatic logic [WORD_W-1:0] byte_swap32(input logic [WORD_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

@@ rtl/mdpad_ctrl.sv @@
// Controller state machine of the message padder: input handshake and padding sequencing.
// Depends on mdpad_pkg for the command and status structs.
module mdpad_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_cmd,
    output logic                s_tready,
    input  mdpad_pkg::mdpad_stat_t stat,
    output mdpad_pkg::mdpad_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_DATA = 2'b01,
        S_PAD  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_fire;

    assign s_tready = (state_reg == S_DATA) && stat.slot_free;
    assign in_fire  = s_tvalid && s_tready;

    always_comb begin
        cmd.load_byte = in_fire && (s_cmd == mdpad_pkg::CMD_APPEND);
        cmd.start_pad = in_fire && (s_cmd == mdpad_pkg::CMD_FINISH);
        cmd.emit_pad  = (state_reg == S_PAD) && stat.slot_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_DATA: begin
                if (cmd.start_pad) begin
                    state_next = S_PAD;
                end
            end
            S_PAD: begin
                if (cmd.emit_pad && stat.pad_last) begin
                    state_next = S_DATA;
                end
            end
            default: state_next = S_DATA;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_DATA;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/mdpad_datapath.sv @@
// Datapath of the message padder: byte count, word packing, padding words and output register.
// Depends on mdpad_pkg for constants, structs and the byte swap function.
module mdpad_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mdpad_pkg::mdpad_cmd_t               cmd,
    output mdpad_pkg::mdpad_stat_t              stat,
    input  logic [mdpad_pkg::BYTE_W-1:0]        in_byte,
    input  logic                                cfg_we,
    input  logic                                cfg_data,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [mdpad_pkg::WORD_W-1:0]        m_tdata,
    output logic [1:0]                          m_tuser,
    output logic                                m_tlast
);

    logic [mdpad_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [mdpad_pkg::PARTIAL_W-1:0] partial_reg, partial_next;
    logic                            algorithm_reg;

    logic [mdpad_pkg::WIDX_W-1:0]    pad_widx_reg, pad_widx_next;
    logic                            pad_first_reg, pad_first_next;
    logic                            pad_extra_reg, pad_extra_next;
    logic                            pad_init_reg, pad_init_next;

    logic                            out_valid_reg, out_valid_next;
    logic [mdpad_pkg::WORD_W-1:0]    out_word_reg, out_word_next;
    logic                            out_first_reg, out_first_next;
    logic                            out_bend_reg, out_bend_next;
    logic                            out_last_reg, out_last_next;

    logic [1:0]                      k;
    logic                            cnt_first;
    logic [63:0]                     bit_len;
    logic [mdpad_pkg::WORD_W-1:0]    init_word;
    logic [mdpad_pkg::WORD_W-1:0]    pad_word;
    logic                            pad_last;

    assign k         = count_reg[1:0];
    assign cnt_first = (count_reg[mdpad_pkg::COUNT_W-1:6] == '0);
    assign bit_len   = {count_reg, 3'b000};
    assign pad_last  = (pad_widx_reg == mdpad_pkg::LAST_WIDX) && !pad_extra_reg;

    assign stat.slot_free = !out_valid_reg || m_tready;
    assign stat.pad_last  = pad_last;

    // First padding word: pending bytes, then the 0x80 marker byte.
    always_comb begin
        unique case (k)
            2'd0: init_word = {mdpad_pkg::PAD_BYTE, 24'h0};
            2'd1: init_word = {partial_reg[7:0], mdpad_pkg::PAD_BYTE, 16'h0};
            2'd2: init_word = {partial_reg[15:0], mdpad_pkg::PAD_BYTE, 8'h0};
            2'd3: init_word = {partial_reg, mdpad_pkg::PAD_BYTE};
            default: init_word = '0;
        endcase
    end

    always_comb begin
        priority if (pad_init_reg) begin
            pad_word = init_word;
        end else if (!pad_extra_reg && (pad_widx_reg == mdpad_pkg::LEN_HI_WIDX)) begin
            pad_word = (algorithm_reg == mdpad_pkg::ALG_MD5) ?
                       mdpad_pkg::byte_swap32(bit_len[31:0]) : bit_len[63:32];
        end else if (pad_last) begin
            pad_word = (algorithm_reg == mdpad_pkg::ALG_MD5) ?
                       mdpad_pkg::byte_swap32(bit_len[63:32]) : bit_len[31:0];
        end else begin
            pad_word = '0;
        end
    end

    always_comb begin
        count_next     = count_reg;
        partial_next   = partial_reg;
        pad_widx_next  = pad_widx_reg;
        pad_first_next = pad_first_reg;
        pad_extra_next = pad_extra_reg;
        pad_init_next  = pad_init_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_word_next  = out_word_reg;
        out_first_next = out_first_reg;
        out_bend_next  = out_bend_reg;
        out_last_next  = out_last_reg;

        if (cmd.load_byte) begin
            count_next = count_reg + 1'b1;
            if (k == 2'd3) begin
                partial_next   = '0;
                out_valid_next = 1'b1;
                out_word_next  = {partial_reg, in_byte};
                out_first_next = cnt_first;
                out_bend_next  = (count_reg[5:2] == mdpad_pkg::LAST_WIDX);
                out_last_next  = 1'b0;
            end else begin
                partial_next = {partial_reg[15:0], in_byte};
            end
        end

        if (cmd.start_pad) begin
            pad_widx_next  = count_reg[5:2];
            pad_first_next = cnt_first;
            pad_extra_next = (count_reg[5:0] >= mdpad_pkg::LEN_START_BYTE);
            pad_init_next  = 1'b1;
        end

        if (cmd.emit_pad) begin
            out_valid_next = 1'b1;
            out_word_next  = pad_word;
            out_first_next = pad_first_reg;
            out_bend_next  = (pad_widx_reg == mdpad_pkg::LAST_WIDX);
            out_last_next  = pad_last;
            pad_init_next  = 1'b0;
            if ((pad_widx_reg == mdpad_pkg::LAST_WIDX) && pad_extra_reg) begin
                // Second padding block follows; it is never the first block.
                pad_widx_next  = '0;
                pad_extra_next = 1'b0;
                pad_first_next = 1'b0;
            end else begin
                pad_widx_next = pad_widx_reg + 1'b1;
            end
            if (pad_last) begin
                count_next   = '0;
                partial_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            partial_reg   <= '0;
            algorithm_reg <= mdpad_pkg::ALG_SHA1;
            out_valid_reg <= 1'b0;
            pad_init_reg  <= 1'b0;
            pad_extra_reg <= 1'b0;
            pad_widx_reg  <= '0;
            pad_first_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            partial_reg   <= partial_next;
            out_valid_reg <= out_valid_next;
            pad_init_reg  <= pad_init_next;
            pad_extra_reg <= pad_extra_next;
            pad_widx_reg  <= pad_widx_next;
            pad_first_reg <= pad_first_next;
            if (cfg_we) begin
                algorithm_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_word_reg  <= out_word_next;
        out_first_reg <= out_first_next;
        out_bend_reg  <= out_bend_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tuser  = {out_bend_reg, out_first_reg};
    assign m_tlast  = out_last_reg;

endmodule

@@ rtl/md_hash_message_padder.sv @@
// Top level of the MD5 / SHA-1 message padder: controller plus datapath.
// Depends on mdpad_pkg, mdpad_ctrl and mdpad_datapath.

// The padder takes message bytes one per transfer and packs each four bytes into a
// 32-bit word, first byte in bits 31 to 24, emitting one word transfer for every fourth
// byte. A byte transfer is taken in every cycle as long as the output register is free
// or being drained, so data runs at one byte per cycle. A finish transfer closes the
// message: the padder then emits, one word per cycle unless the output stalls, the word
// holding the pending bytes and the 0x80 marker, zero words, and the 64-bit bit length
// (big-endian for SHA-1, byte-swapped low word first for MD5), which is 3 to 16 words or,
// when 56 or more bytes of the last block are in use, 17 or 18 words in total. No new input
// is accepted until the last word of the padding has entered the output register. Every
// output word carries a first-block flag and an end-of-block flag, and the last padding
// word carries tlast. The byte count wraps modulo 2^61 and returns to zero after every
// finish. The algorithm register should only be written while no message is being padded.
module md_hash_message_padder (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] command: 0 append byte, 1 finish message
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] message_word
    output logic [1:0]  m_tuser,   // [0] first_block, [1] block_end
    output logic        m_tlast,   // message_end
    // Configuration channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // algorithm: 0 SHA-1, 1 MD5
);

    mdpad_pkg::mdpad_cmd_t  cmd;
    mdpad_pkg::mdpad_stat_t stat;

    // The register write is always taken in the cycle it is offered.
    assign cfg_ready = 1'b1;

    mdpad_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mdpad_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_byte  (s_tdata),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ rtl/mdpad_checker.sv @@
// Port-level checks of the message padder, attached to the top level by bind.
// Depends only on the ports of md_hash_message_padder.
module mdpad_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled output blocks the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

    // After a finish transfer the padder is busy padding.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> !s_tready)
        else $error("input taken right after finish");

    // The final word of a message always ends a block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser[1])
        else $error("message end not on block end");

    // A stalled result holds its word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind md_hash_message_padder mdpad_checker u_mdpad_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
